@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the spectrum block.
// Both macros sample on i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define RDSC_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define RDSC_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdsc_pkg
// Constants, tables and shared types of the real DFT half-spectrum block.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    // record and field geometry
    localparam int RECORD_LENGTH = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int IDX_W         = $clog2(RECORD_LENGTH);
    localparam int NBINS         = RECORD_LENGTH / 2 + 1;
    localparam int BIN_W         = 6;
    localparam int VAL_W         = 23;
    localparam int MAG_W         = 22;
    localparam int ANG_W         = 16;

    // CORDIC
    localparam int CORDIC_STEPS  = 30;
    localparam int STEP_W        = 5;
    localparam int CX_W          = 36;
    localparam int TW_W          = 32;
    localparam logic signed [CX_W-1:0] INV_GAIN_Q30 = 36'sd652032874;

    // sqrt(2) in Q23
    localparam logic [23:0] SQRT2_Q23 = 24'd11863283;

    // atan(2^-i) in units of 2^-32 turn
    typedef logic [29:0] t_atan_tab [CORDIC_STEPS];
    localparam t_atan_tab ATAN_TURN = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,         30'd3,        30'd1
    };

    // twiddle angle of index m: round(m * 2^32 / N) in 2^-32 turn
    function automatic logic [31:0] twiddle_turn(input logic [IDX_W-1:0] m);
        logic [IDX_W+32:0] num;
        num = {1'b0, m, 32'b0} + (IDX_W+33)'(RECORD_LENGTH / 2);
        return 32'(num / RECORD_LENGTH);
    endfunction

    // request to / response from the shared CORDIC unit
    typedef struct packed {
        logic                   start;
        logic                   vec;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CX_W-1:0] z;
    } t_cordic_req;

    typedef struct packed {
        logic                   done;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CX_W-1:0] z;
    } t_cordic_rsp;

endpackage

@@ rtl/core/rdsc_if.sv @@
// ----------------------------------------------------------------------------
// rdsc_if
// Valid/ready channels of the spectrum block: sample items in, bin items out.
// ----------------------------------------------------------------------------
interface rdsc_sample_if import rdsc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rdsc_bin_if import rdsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [BIN_W-1:0]        bin_index;
    logic signed [VAL_W-1:0] real_value;
    logic signed [VAL_W-1:0] imag_value;
    logic [MAG_W-1:0]        magnitude;
    logic signed [ANG_W-1:0] angle;
    logic                    last_bin;

    modport source (output valid, output bin_index, output real_value, output imag_value,
                    output magnitude, output angle, output last_bin, input ready);
    modport sink   (input valid, input bin_index, input real_value, input imag_value,
                    input magnitude, input angle, input last_bin, output ready);
endinterface

@@ rtl/core/rdsc_ram.sv @@
// ----------------------------------------------------------------------------
// rdsc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rdsc_cordic.sv @@
// ----------------------------------------------------------------------------
// rdsc_cordic
// Iterative CORDIC, one micro-rotation per cycle. Rotation mode builds the
// twiddles; vectoring mode normalizes the pair and then yields the angle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdsc_cordic import rdsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    localparam logic signed [CX_W-1:0] NORM_LIM = 36'sd536870912;

    t_cstate                r_state;
    logic                   r_vec;
    logic                   r_done;
    logic [STEP_W-1:0]      r_i;
    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [CX_W-1:0] r_z;

    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [CX_W-1:0] at;
    logic signed [CX_W-1:0] ax;
    logic signed [CX_W-1:0] ay;
    logic                   ccw;
    logic                   below_lim;

    // micro-rotation terms
    always_comb begin
        xs        = r_x >>> r_i;
        ys        = r_y >>> r_i;
        at        = $signed({6'b0, ATAN_TURN[r_i]});
        ax        = (r_x < 0) ? -r_x : r_x;
        ay        = (r_y < 0) ? -r_y : r_y;
        ccw       = r_vec ? !(r_y > 0) : (r_z >= 0);
        below_lim = (ax < NORM_LIM) && (ay < NORM_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_y     <= i_req.y;
                        r_z     <= i_req.z;
                        r_vec   <= i_req.vec;
                        r_i     <= '0;
                        r_state <= i_req.vec ? C_NORM : C_ITER;
                    end
                end
                // left shift until the larger component reaches 2^29
                C_NORM: begin
                    if (below_lim) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (ccw) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                    if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;

    `RDSC_AST_IMP(a_start_idle, i_req.start, r_state == C_IDLE, "cordic started while busy")
    `RDSC_AST_IMP(a_done_idle, r_done, r_state == C_IDLE, "cordic done while still busy")
    `RDSC_AST_IMP(a_iter_range, r_state == C_ITER, r_i < STEP_W'(CORDIC_STEPS), "step overrun")

endmodule

@@ rtl/core/real_dft_spectrum_components.sv @@
// ----------------------------------------------------------------------------
// real_dft_spectrum_components
// Collects a record of samples, then emits the scaled DFT half spectrum:
// real, imaginary, magnitude and phase per bin.
// ----------------------------------------------------------------------------
//  channel   dir  item                                         handshake
//  i_sample  in   sample (16b signed)                          valid/ready
//  o_bin     out  bin_index, real_value, imag_value,           valid/ready
//                 magnitude, angle, last_bin
//
//  A sample that does not close a record is taken while i_sample.ready is high
//  in S_FILL. The closing sample starts 33 bins, each built in steps: the
//  MACs through the sample and twiddle RAM ports, the sqrt(2) scaling (scaled
//  bins only), the squares, the 32-step square root and the emit. The angle
//  search can hold a bin before its emit.
//  After reset a twiddle build pass of 64 CORDIC runs holds i_sample.ready
//  low. A stalled o_bin holds the next bin in S_EMIT.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module real_dft_spectrum_components import rdsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rdsc_sample_if.sink  i_sample,
    rdsc_bin_if.source   o_bin
);

    localparam int PRD_W  = SAMPLE_BITS + TW_W;
    localparam int ACC_W  = PRD_W + IDX_W + 1;
    localparam int Q16_W  = 40;
    localparam int Q8_W   = 32;
    localparam int MA_W   = 21;
    localparam int MB_W   = 25;
    localparam int MP_W   = MA_W + MB_W;
    localparam int WACC_W = 66;
    localparam int SQ_W   = 64;

    localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(64'sd274877906944);
    localparam logic signed [ACC_W-1:0] CLAMP_LO = -CLAMP_HI;
    localparam logic signed [Q16_W-1:0] VAL_HI = 40'sd4194303;
    localparam logic signed [Q16_W-1:0] VAL_LO = -40'sd4194304;
    localparam logic [SQ_W-1:0]         MAG_HI = 64'd4194303;
    localparam logic signed [CX_W-1:0]  HALF_TURN = 36'sd2147483648;
    localparam logic signed [CX_W-1:0]  ANG_HI = 36'sd32767;
    localparam logic signed [CX_W-1:0]  ANG_LO = -36'sd32768;

    typedef enum logic [3:0] {
        S_INIT_GO, S_INIT_WAIT, S_FILL, S_ACC, S_Q16, S_MUL, S_ADD,
        S_RE_SCL, S_IM_SCL, S_Q8, S_SQ_LOAD, S_SQRT, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        ST_RE_HI, ST_RE_LO, ST_IM_HI, ST_IM_LO,
        ST_RR_HH, ST_RR_HL, ST_RR_LL, ST_II_HH, ST_II_HL, ST_II_LL
    } t_step;

    // control
    t_state                  r_state;
    t_step                   r_step;
    logic [IDX_W-1:0]        r_tw_m;
    logic                    r_tw_neg;
    logic [IDX_W-1:0]        r_fill;
    logic [BIN_W-1:0]        r_k;
    logic [IDX_W:0]          r_n;
    logic [IDX_W-1:0]        r_m;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_cdone;
    logic                    r_zero;
    logic                    r_ov;

    // datapath
    logic signed [PRD_W-1:0] r_pre;
    logic signed [PRD_W-1:0] r_pim;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic signed [Q16_W-1:0] r_re;
    logic signed [Q16_W-1:0] r_im;
    logic [Q8_W-1:0]         r_are;
    logic [Q8_W-1:0]         r_aim;
    logic signed [MP_W-1:0]  r_prod;
    logic signed [WACC_W-1:0] r_wacc;
    logic [SQ_W-1:0]         r_rem;
    logic [SQ_W-1:0]         r_root;
    logic [SQ_W-1:0]         r_bit;
    logic signed [VAL_W-1:0] r_out_re;
    logic signed [VAL_W-1:0] r_out_im;

    // output slot
    logic [BIN_W-1:0]        r_o_bin;
    logic signed [VAL_W-1:0] r_o_re;
    logic signed [VAL_W-1:0] r_o_im;
    logic [MAG_W-1:0]        r_o_mag;
    logic signed [ANG_W-1:0] r_o_ang;
    logic                    r_o_last;

    // combinational
    logic                    smp_acc;
    logic                    smp_we;
    logic [SAMPLE_BITS-1:0]  smp_rdata;
    logic                    tw_we;
    logic [2*TW_W-1:0]       tw_wdata;
    logic [2*TW_W-1:0]       tw_rdata;
    logic                    issue;
    logic [IDX_W:0]          m_sum;
    logic [IDX_W-1:0]        n_m;
    logic [31:0]             turn;
    logic [31:0]             turn_f;
    logic                    fold_neg;
    logic signed [Q16_W-1:0] re8_w;
    logic signed [Q16_W-1:0] im8_w;
    logic signed [Q8_W-1:0]  re8;
    logic signed [Q8_W-1:0]  im8;
    logic                    zero_c;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [WACC_W-1:0] p_ext;
    logic signed [WACC_W-1:0] add_term;
    logic signed [WACC_W-1:0] n_wacc;
    logic signed [WACC_W-1:0] wacc_rs23;
    logic [SQ_W-1:0]         rb_sum;
    logic [SQ_W-1:0]         mag_t;
    logic signed [CX_W-1:0]  ang_t;
    logic [MAG_W-1:0]        mag_c;
    logic signed [ANG_W-1:0] ang_c;
    logic                    scaled;
    logic                    out_free;
    logic                    emit_go;
    t_cordic_req             creq;
    t_cordic_rsp             crsp;

    // Q30 sum to Q16, clamped
    function automatic logic signed [Q16_W-1:0] q16_of(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + ACC_W'(64'sd8192)) >>> 14;
        if (t > CLAMP_HI) begin
            t = CLAMP_HI;
        end else if (t < CLAMP_LO) begin
            t = CLAMP_LO;
        end
        return t[Q16_W-1:0];
    endfunction

    // Q16 to integer output, saturated
    function automatic logic signed [VAL_W-1:0] val_of(input logic signed [Q16_W-1:0] q);
        logic signed [Q16_W-1:0] t;
        t = (q + 40'sd32768) >>> 16;
        if (t > VAL_HI) begin
            t = VAL_HI;
        end else if (t < VAL_LO) begin
            t = VAL_LO;
        end
        return t[VAL_W-1:0];
    endfunction

    // -------------------------------------------------------------- memories
    rdsc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RECORD_LENGTH)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (r_fill),
        .i_wdata (i_sample.sample),
        .i_raddr (r_n[IDX_W-1:0]),
        .o_rdata (smp_rdata)
    );

    rdsc_ram #(.WIDTH(2 * TW_W), .DEPTH(RECORD_LENGTH)) u_tw_ram (
        .i_clk   (i_clk),
        .i_we    (tw_we),
        .i_waddr (r_tw_m),
        .i_wdata (tw_wdata),
        .i_raddr (r_m),
        .o_rdata (tw_rdata)
    );

    rdsc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (creq),
        .o_rsp   (crsp)
    );

    // ------------------------------------------------------------- handshake
    assign i_sample.ready = (r_state == S_FILL);
    assign smp_acc        = i_sample.valid && i_sample.ready;
    assign smp_we         = smp_acc;
    assign out_free       = !r_ov || o_bin.ready;
    assign emit_go        = (r_state == S_EMIT) && r_cdone && out_free;

    // twiddle build: fold angle into [-90, 90) degrees
    always_comb begin
        turn     = twiddle_turn(r_tw_m);
        turn_f   = turn + 32'h4000_0000;
        fold_neg = turn_f[31];
        if (fold_neg) begin
            turn = turn + 32'h8000_0000;
        end
        tw_we    = (r_state == S_INIT_WAIT) && crsp.done;
        tw_wdata = r_tw_neg ? {TW_W'(-crsp.x), TW_W'(-crsp.y)}
                            : {TW_W'(crsp.x), TW_W'(crsp.y)};
    end

    // MAC address walk: m = k*n mod N
    always_comb begin
        issue = (r_state == S_ACC) && (r_n < (IDX_W+1)'(RECORD_LENGTH));
        m_sum = {1'b0, r_m} + (IDX_W+1)'(r_k);
        if (m_sum >= (IDX_W+1)'(RECORD_LENGTH)) begin
            m_sum = m_sum - (IDX_W+1)'(RECORD_LENGTH);
        end
        n_m = m_sum[IDX_W-1:0];
    end

    // Q8 values and the vectoring request
    always_comb begin
        re8_w  = (r_re + 40'sd128) >>> 8;
        im8_w  = (r_im + 40'sd128) >>> 8;
        re8    = re8_w[Q8_W-1:0];
        im8    = im8_w[Q8_W-1:0];
        zero_c = (re8 == '0) && (im8 == '0);
        scaled = (r_k != '0) &&
                 !((RECORD_LENGTH % 2 == 0) && (r_k == BIN_W'(RECORD_LENGTH / 2)));

        creq       = '0;
        creq.start = 1'b0;
        if (r_state == S_INIT_GO) begin
            creq.start = 1'b1;
            creq.vec   = 1'b0;
            creq.x     = INV_GAIN_Q30;
            creq.y     = '0;
            creq.z     = CX_W'($signed(turn));
        end else if (r_state == S_Q8 && !zero_c) begin
            creq.start = 1'b1;
            creq.vec   = 1'b1;
            if (re8 < 0) begin
                creq.x = -CX_W'(re8);
                creq.y = -CX_W'(im8);
                creq.z = (im8 >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                creq.x = CX_W'(re8);
                creq.y = CX_W'(im8);
                creq.z = '0;
            end
        end
    end

    // shared multiplier operands and the shifted partial product
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        p_ext = WACC_W'(r_prod);
        add_term = p_ext;
        unique case (r_step)
            ST_RE_HI: begin
                mul_a = {r_re[Q16_W-1], r_re[Q16_W-1:20]};
                mul_b = $signed({1'b0, SQRT2_Q23});
                add_term = p_ext <<< 20;
            end
            ST_RE_LO: begin
                mul_a = $signed({1'b0, r_re[19:0]});
                mul_b = $signed({1'b0, SQRT2_Q23});
            end
            ST_IM_HI: begin
                mul_a = {r_im[Q16_W-1], r_im[Q16_W-1:20]};
                mul_b = $signed({1'b0, SQRT2_Q23});
                add_term = p_ext <<< 20;
            end
            ST_IM_LO: begin
                mul_a = $signed({1'b0, r_im[19:0]});
                mul_b = $signed({1'b0, SQRT2_Q23});
            end
            ST_RR_HH: begin
                mul_a = $signed({5'b0, r_are[31:16]});
                mul_b = $signed({9'b0, r_are[31:16]});
                add_term = p_ext <<< 32;
            end
            ST_RR_HL: begin
                mul_a = $signed({5'b0, r_are[31:16]});
                mul_b = $signed({9'b0, r_are[15:0]});
                add_term = p_ext <<< 17;
            end
            ST_RR_LL: begin
                mul_a = $signed({5'b0, r_are[15:0]});
                mul_b = $signed({9'b0, r_are[15:0]});
            end
            ST_II_HH: begin
                mul_a = $signed({5'b0, r_aim[31:16]});
                mul_b = $signed({9'b0, r_aim[31:16]});
                add_term = p_ext <<< 32;
            end
            ST_II_HL: begin
                mul_a = $signed({5'b0, r_aim[31:16]});
                mul_b = $signed({9'b0, r_aim[15:0]});
                add_term = p_ext <<< 17;
            end
            ST_II_LL: begin
                mul_a = $signed({5'b0, r_aim[15:0]});
                mul_b = $signed({9'b0, r_aim[15:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_wacc    = r_wacc + add_term;
        wacc_rs23 = (r_wacc + 66'sd4194304) >>> 23;
    end

    // magnitude and angle rounding
    always_comb begin
        rb_sum = r_root + r_bit;
        mag_t  = (r_root + 64'd128) >> 8;
        mag_c  = (mag_t > MAG_HI) ? MAG_HI[MAG_W-1:0] : mag_t[MAG_W-1:0];
        ang_t  = (crsp.z + 36'sd32768) >>> 16;
        if (ang_t > ANG_HI) begin
            ang_t = ANG_HI;
        end else if (ang_t < ANG_LO) begin
            ang_t = ANG_LO;
        end
        ang_c = r_zero ? '0 : ang_t[ANG_W-1:0];
    end

    // ---------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_GO;
            r_tw_m  <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_cdone <= 1'b0;
            r_zero  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output slot: load on emit, free on accept
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (o_bin.ready) begin
                r_ov <= 1'b0;
            end
            if (crsp.done) begin
                r_cdone <= 1'b1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;

            unique case (r_state)
                S_INIT_GO: begin
                    r_tw_neg <= fold_neg;
                    r_state  <= S_INIT_WAIT;
                end
                S_INIT_WAIT: begin
                    if (crsp.done) begin
                        if (r_tw_m == IDX_W'(RECORD_LENGTH - 1)) begin
                            r_state <= S_FILL;
                        end else begin
                            r_tw_m  <= r_tw_m + 1'b1;
                            r_state <= S_INIT_GO;
                        end
                    end
                end
                S_FILL: begin
                    if (smp_acc) begin
                        if (r_fill == IDX_W'(RECORD_LENGTH - 1)) begin
                            r_fill   <= '0;
                            r_k      <= '0;
                            r_n      <= '0;
                            r_m      <= '0;
                            r_acc_re <= '0;
                            r_acc_im <= '0;
                            r_state  <= S_ACC;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                // issue, multiply, accumulate
                S_ACC: begin
                    if (issue) begin
                        r_n <= r_n + 1'b1;
                        r_m <= n_m;
                    end
                    if (r_v1) begin
                        r_pre <= $signed(smp_rdata) * $signed(tw_rdata[2*TW_W-1:TW_W]);
                        r_pim <= $signed(smp_rdata) * $signed(tw_rdata[TW_W-1:0]);
                    end
                    if (r_v2) begin
                        r_acc_re <= r_acc_re + ACC_W'(r_pre);
                        r_acc_im <= r_acc_im - ACC_W'(r_pim);
                    end
                    if (!issue && !r_v1 && !r_v2) begin
                        r_state <= S_Q16;
                    end
                end
                S_Q16: begin
                    r_re   <= q16_of(r_acc_re);
                    r_im   <= q16_of(r_acc_im);
                    r_wacc <= '0;
                    r_step <= ST_RE_HI;
                    r_state <= scaled ? S_MUL : S_Q8;
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_wacc <= n_wacc;
                    priority case (r_step)
                        ST_RE_LO: r_state <= S_RE_SCL;
                        ST_IM_LO: r_state <= S_IM_SCL;
                        ST_II_LL: r_state <= S_SQ_LOAD;
                        default: begin
                            r_step  <= t_step'(r_step + 1'b1);
                            r_state <= S_MUL;
                        end
                    endcase
                end
                S_RE_SCL: begin
                    r_re    <= wacc_rs23[Q16_W-1:0];
                    r_wacc  <= '0;
                    r_step  <= ST_IM_HI;
                    r_state <= S_MUL;
                end
                S_IM_SCL: begin
                    r_im    <= wacc_rs23[Q16_W-1:0];
                    r_state <= S_Q8;
                end
                // Q8 pair, outputs, start angle search
                S_Q8: begin
                    r_are    <= (re8 < 0) ? Q8_W'(-re8) : Q8_W'(re8);
                    r_aim    <= (im8 < 0) ? Q8_W'(-im8) : Q8_W'(im8);
                    r_out_re <= val_of(r_re);
                    r_out_im <= val_of(r_im);
                    r_zero   <= zero_c;
                    r_cdone  <= zero_c;
                    r_wacc   <= '0;
                    r_step   <= ST_RR_HH;
                    r_state  <= S_MUL;
                end
                S_SQ_LOAD: begin
                    r_rem   <= r_wacc[SQ_W-1:0];
                    r_root  <= '0;
                    r_bit   <= SQ_W'(64'd1) << 62;
                    r_state <= S_SQRT;
                end
                // bit-pair square root, one digit a cycle
                S_SQRT: begin
                    if (r_rem >= rb_sum) begin
                        r_rem  <= r_rem - rb_sum;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_o_bin  <= r_k;
                        r_o_re   <= r_out_re;
                        r_o_im   <= r_out_im;
                        r_o_mag  <= mag_c;
                        r_o_ang  <= ang_c;
                        r_o_last <= (r_k == BIN_W'(NBINS - 1));
                        if (r_k == BIN_W'(NBINS - 1)) begin
                            r_state <= S_FILL;
                        end else begin
                            r_k      <= r_k + 1'b1;
                            r_n      <= '0;
                            r_m      <= '0;
                            r_acc_re <= '0;
                            r_acc_im <= '0;
                            r_state  <= S_ACC;
                        end
                    end
                end
                default: r_state <= S_INIT_GO;
            endcase
        end
    end

    assign o_bin.valid      = r_ov;
    assign o_bin.bin_index  = r_o_bin;
    assign o_bin.real_value = r_o_re;
    assign o_bin.imag_value = r_o_im;
    assign o_bin.magnitude  = r_o_mag;
    assign o_bin.angle      = r_o_ang;
    assign o_bin.last_bin   = r_o_last;

    `RDSC_AST_IMP(a_last_index, o_bin.valid && o_bin.last_bin, o_bin.bin_index == BIN_W'(NBINS - 1), "last bin flag on wrong bin")
    `RDSC_AST_NXT(a_record_start, smp_acc && r_fill == IDX_W'(RECORD_LENGTH - 1), r_state == S_ACC, "record end did not start the transform")
    `RDSC_AST_IMP(a_mac_in_acc, r_v1 || r_v2, r_state == S_ACC, "MAC pipe busy outside accumulation")

endmodule
